### rtl/hsgf_pkg.sv
// Shared types, constants and tables for the haversine geofence lock.
// Used by hsgf_ctrl, hsgf_dp and haversine_geofence_lock_unit.
`timescale 1ns / 1ps
`default_nettype none
package hsgf_pkg;

  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] GAIN_Q30    = 32'd652032874;
  localparam logic [31:0] Q_ONE       = 32'd1073741824;
  localparam logic [31:0] DEN_HALF    = 32'd3600000000;
  localparam logic [31:0] DEN_LAT     = 32'd1800000000;
  // both divisors are DIV_ODD << 10 and DIV_ODD << 9
  localparam logic [31:0] DIV_ODD     = 32'd3515625;
  localparam logic [31:0] DIV_RECIP   = 32'd2562047788;  // floor(2^53 / DIV_ODD)
  localparam logic [31:0] TWO_R_M     = 32'd12742000;
  localparam logic [24:0] ANTIPODAL_M = 25'd20015087;
  localparam logic [24:0] RADIUS_RST  = 25'd100;
  localparam logic [6:0]  SERVO_LOCK   = 7'd0;
  localparam logic [6:0]  SERVO_UNLOCK = 7'd90;
  localparam int          ATAN_LEN    = 48;
  localparam int          DIV_STEPS   = 5;
  localparam int          SQRT_STEPS  = 31;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_TARGET_LAT = 2'd0,
    REG_TARGET_LON = 2'd1,
    REG_RADIUS     = 2'd2
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_MUL_RAD, OP_DIV_LD, OP_DIV_STEP, OP_ROT_LD, OP_ROT_STEP,
    OP_TRIG_MUL, OP_TRIG_ST, OP_CPROD, OP_TERM, OP_SUM, OP_SQA_LD, OP_SQ_STEP,
    OP_SQB_LD, OP_VEC_LD, OP_VEC_STEP, OP_DIST_MUL, OP_FINISH
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL, ST_DIV_LD, ST_DIV, ST_ROT_LD, ST_ROT, ST_TMUL, ST_TST,
    ST_CPROD, ST_TERM, ST_SUM, ST_SQA_LD, ST_SQA, ST_SQB_LD, ST_SQB, ST_VEC_LD,
    ST_VEC, ST_DMUL, ST_FIN
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] job;   // 0 lat half diff, 1 lon half diff, 2 fix lat, 3 target lat
    logic [5:0] iter;
  } cmd_t;

  function automatic logic [31:0] atan_q30(input logic [5:0] i);
    logic [31:0] r;
    case (i)
      6'd0:  r = 32'd843314857;
      6'd1:  r = 32'd497837829;
      6'd2:  r = 32'd263043837;
      6'd3:  r = 32'd133525159;
      6'd4:  r = 32'd67021687;
      6'd5:  r = 32'd33543516;
      6'd6:  r = 32'd16775851;
      6'd7:  r = 32'd8388437;
      6'd8:  r = 32'd4194283;
      6'd9:  r = 32'd2097149;
      default: r = (i <= 6'd30) ? (32'd1 << (6'd30 - i)) : 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat_lat(input logic signed [30:0] v);
    logic signed [31:0] w;
    w = 32'(v);
    if (w > 32'sd900000000) return 32'sd900000000;
    if (w < -32'sd900000000) return -32'sd900000000;
    return w;
  endfunction

  function automatic logic signed [31:0] sat_lon(input logic signed [31:0] v);
    if (v > 32'sd1800000000) return 32'sd1800000000;
    if (v < -32'sd1800000000) return -32'sd1800000000;
    return v;
  endfunction

endpackage
`default_nettype wire

### rtl/hsgf_ctrl.sv
// Sequencer for the geofence datapath: issues one command per cycle.
// Depends on hsgf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hsgf_ctrl #(
  parameter int ITERS = 32
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire              out_stall,
  output hsgf_pkg::cmd_t   cmd
);

  localparam logic [5:0] LAST_ROT  = 6'(ITERS - 1);
  localparam logic [5:0] LAST_DIV  = 6'(hsgf_pkg::DIV_STEPS - 1);
  localparam logic [5:0] LAST_SQRT = 6'(hsgf_pkg::SQRT_STEPS - 1);

  hsgf_pkg::state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [1:0] job_r, job_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       fin_go;

  assign fin_go = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hsgf_pkg::ST_IDLE;
      cnt_r       <= '0;
      job_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      job_r       <= job_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 6'd1;
    job_nxt   = job_r;
    unique case (state_r)
      hsgf_pkg::ST_IDLE:   begin
        job_nxt = '0;
        if (in_valid) state_nxt = hsgf_pkg::ST_MUL;
      end
      hsgf_pkg::ST_MUL:    state_nxt = hsgf_pkg::ST_DIV_LD;
      hsgf_pkg::ST_DIV_LD: begin
        state_nxt = hsgf_pkg::ST_DIV;
        cnt_nxt   = '0;
      end
      hsgf_pkg::ST_DIV:    if (cnt_r == LAST_DIV) state_nxt = hsgf_pkg::ST_ROT_LD;
      hsgf_pkg::ST_ROT_LD: begin
        state_nxt = hsgf_pkg::ST_ROT;
        cnt_nxt   = '0;
      end
      hsgf_pkg::ST_ROT:    if (cnt_r == LAST_ROT) state_nxt = hsgf_pkg::ST_TMUL;
      hsgf_pkg::ST_TMUL:   state_nxt = hsgf_pkg::ST_TST;
      hsgf_pkg::ST_TST:    begin
        job_nxt   = job_r + 2'd1;
        state_nxt = (job_r == 2'd3) ? hsgf_pkg::ST_CPROD : hsgf_pkg::ST_MUL;
      end
      hsgf_pkg::ST_CPROD:  state_nxt = hsgf_pkg::ST_TERM;
      hsgf_pkg::ST_TERM:   state_nxt = hsgf_pkg::ST_SUM;
      hsgf_pkg::ST_SUM:    state_nxt = hsgf_pkg::ST_SQA_LD;
      hsgf_pkg::ST_SQA_LD: begin
        state_nxt = hsgf_pkg::ST_SQA;
        cnt_nxt   = '0;
      end
      hsgf_pkg::ST_SQA:    if (cnt_r == LAST_SQRT) state_nxt = hsgf_pkg::ST_SQB_LD;
      hsgf_pkg::ST_SQB_LD: begin
        state_nxt = hsgf_pkg::ST_SQB;
        cnt_nxt   = '0;
      end
      hsgf_pkg::ST_SQB:    if (cnt_r == LAST_SQRT) state_nxt = hsgf_pkg::ST_VEC_LD;
      hsgf_pkg::ST_VEC_LD: begin
        state_nxt = hsgf_pkg::ST_VEC;
        cnt_nxt   = '0;
      end
      hsgf_pkg::ST_VEC:    if (cnt_r == LAST_ROT) state_nxt = hsgf_pkg::ST_DMUL;
      hsgf_pkg::ST_DMUL:   state_nxt = hsgf_pkg::ST_FIN;
      hsgf_pkg::ST_FIN:    if (fin_go) state_nxt = hsgf_pkg::ST_IDLE;
      default:             state_nxt = hsgf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.job  = job_r;
    cmd.iter = cnt_r;
    cmd.op   = hsgf_pkg::OP_NOP;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      hsgf_pkg::ST_IDLE:   if (in_valid) cmd.op = hsgf_pkg::OP_LOAD;
      hsgf_pkg::ST_MUL:    cmd.op = hsgf_pkg::OP_MUL_RAD;
      hsgf_pkg::ST_DIV_LD: cmd.op = hsgf_pkg::OP_DIV_LD;
      hsgf_pkg::ST_DIV:    cmd.op = hsgf_pkg::OP_DIV_STEP;
      hsgf_pkg::ST_ROT_LD: cmd.op = hsgf_pkg::OP_ROT_LD;
      hsgf_pkg::ST_ROT:    cmd.op = hsgf_pkg::OP_ROT_STEP;
      hsgf_pkg::ST_TMUL:   cmd.op = hsgf_pkg::OP_TRIG_MUL;
      hsgf_pkg::ST_TST:    cmd.op = hsgf_pkg::OP_TRIG_ST;
      hsgf_pkg::ST_CPROD:  cmd.op = hsgf_pkg::OP_CPROD;
      hsgf_pkg::ST_TERM:   cmd.op = hsgf_pkg::OP_TERM;
      hsgf_pkg::ST_SUM:    cmd.op = hsgf_pkg::OP_SUM;
      hsgf_pkg::ST_SQA_LD: cmd.op = hsgf_pkg::OP_SQA_LD;
      hsgf_pkg::ST_SQA:    cmd.op = hsgf_pkg::OP_SQ_STEP;
      hsgf_pkg::ST_SQB_LD: cmd.op = hsgf_pkg::OP_SQB_LD;
      hsgf_pkg::ST_SQB:    cmd.op = hsgf_pkg::OP_SQ_STEP;
      hsgf_pkg::ST_VEC_LD: cmd.op = hsgf_pkg::OP_VEC_LD;
      hsgf_pkg::ST_VEC:    cmd.op = hsgf_pkg::OP_VEC_STEP;
      hsgf_pkg::ST_DMUL:   cmd.op = hsgf_pkg::OP_DIST_MUL;
      hsgf_pkg::ST_FIN:    if (fin_go) begin
        cmd.op        = hsgf_pkg::OP_FINISH;
        out_valid_nxt = 1'b1;
      end
      default:             cmd.op = hsgf_pkg::OP_NOP;
    endcase
  end

  assign in_stall  = (state_r != hsgf_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### rtl/hsgf_dp.sv
// Datapath: config registers, shared multiplier, constant divider, CORDIC, isqrt.
// Depends on hsgf_pkg; driven by commands from hsgf_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module hsgf_dp (
  input  wire                clk,
  input  wire                rst_n,
  input  hsgf_pkg::cmd_t     cmd,
  input  wire                cfg_we,
  input  wire  [1:0]         cfg_index,
  input  wire  [31:0]        cfg_wdata,
  input  wire  signed [30:0] in_fix_lat,
  input  wire  signed [31:0] in_fix_lon,
  output logic [24:0]        out_distance_m,
  output logic               out_locked,
  output logic               out_state_changed,
  output logic [6:0]         out_servo_angle
);

  logic signed [31:0] tlat_r, tlon_r;
  logic [24:0]        radius_r;
  logic               lock_r;
  logic               lock_nxt;

  logic signed [31:0] flat_r, dlat_r, dlon_r;
  logic [63:0]        prod_r;
  logic               neg_r;
  logic [31:0]        rem_r, qsh_r;
  logic [52:0]        n_r;
  logic signed [35:0] x_r, y_r, z_r;
  logic [31:0]        hs0_r, hs1_r, c2_r, c3_r, a_r, ra_r;
  logic [61:0]        rad_r;
  logic [32:0]        srem_r;
  logic [30:0]        root_r;
  logic [24:0]        dist_r;
  logic               locked_r, changed_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlat_r   <= '0;
      tlon_r   <= '0;
      radius_r <= hsgf_pkg::RADIUS_RST;
      lock_r   <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hsgf_pkg::REG_TARGET_LAT: tlat_r <= hsgf_pkg::sat_lat(cfg_wdata[30:0]);
          hsgf_pkg::REG_TARGET_LON: tlon_r <= hsgf_pkg::sat_lon(cfg_wdata);
          hsgf_pkg::REG_RADIUS:     radius_r <= cfg_wdata[24:0];
          default: ;
        endcase
      end
      if (cmd.op == hsgf_pkg::OP_FINISH) lock_r <= lock_nxt;
    end
  end

  // input load: saturate, difference, wrap longitude
  logic signed [31:0] flat_s, flon_s;
  logic signed [33:0] dlon_w;
  always_comb begin
    flat_s = hsgf_pkg::sat_lat(in_fix_lat);
    flon_s = hsgf_pkg::sat_lon(in_fix_lon);
    dlon_w = 34'(tlon_r) - 34'(flon_s);
    if (dlon_w > 34'sd1800000000)       dlon_w = dlon_w - 34'sd3600000000;
    else if (dlon_w < -34'sd1800000000) dlon_w = dlon_w + 34'sd3600000000;
  end

  // angle source for the current job
  logic signed [31:0] src;
  logic [31:0]        src_mag, den;
  always_comb begin
    case (cmd.job)
      2'd0:    src = dlat_r;
      2'd1:    src = dlon_r;
      2'd2:    src = flat_r;
      default: src = tlat_r;
    endcase
    src_mag = src[31] ? 32'(-src) : 32'(src);
    den     = cmd.job[1] ? hsgf_pkg::DEN_LAT : hsgf_pkg::DEN_HALF;
  end

  // trig post-processing
  logic signed [35:0] s_abs;
  logic [31:0]        s_cl, c_cl;
  always_comb begin
    s_abs = y_r[35] ? -y_r : y_r;
    s_cl  = (s_abs > 36'(hsgf_pkg::Q_ONE)) ? hsgf_pkg::Q_ONE : s_abs[31:0];
    if (x_r[35])                          c_cl = '0;
    else if (x_r > 36'(hsgf_pkg::Q_ONE))  c_cl = hsgf_pkg::Q_ONE;
    else                                  c_cl = x_r[31:0];
  end

  // shared 32x32 multiplier
  logic [31:0] mul_a, mul_b;
  logic [31:0] z_cl;
  assign z_cl = z_r[35] ? 32'd0 : z_r[31:0];
  always_comb begin
    mul_a = s_cl;
    mul_b = s_cl;
    case (cmd.op)
      hsgf_pkg::OP_MUL_RAD: begin mul_a = src_mag;       mul_b = hsgf_pkg::PI_Q30; end
      // quotient estimate from the top 32 bits, then estimate times divisor
      hsgf_pkg::OP_DIV_STEP: begin
        if (cmd.iter == 6'd0) begin
          mul_a = n_r[52:21];
          mul_b = hsgf_pkg::DIV_RECIP;
        end else begin
          mul_a = prod_r[63:32];
          mul_b = hsgf_pkg::DIV_ODD;
        end
      end
      hsgf_pkg::OP_CPROD:   begin mul_a = c2_r;          mul_b = c3_r; end
      hsgf_pkg::OP_TERM:    begin mul_a = prod_r[61:30]; mul_b = hs1_r; end
      hsgf_pkg::OP_DIST_MUL: begin mul_a = z_cl;         mul_b = hsgf_pkg::TWO_R_M; end
      default: ;
    endcase
  end

  // divider, CORDIC and root steps
  logic [63:0]        num;
  logic [52:0]        n_sh;
  logic               q_fix;
  logic signed [35:0] xs, ys, at, q_s;
  logic               dir;
  logic [34:0]        rem2, trial;
  logic               sge;
  logic [33:0]        a_sum;
  always_comb begin
    num   = prod_r + 64'(den >> 1);
    // strip the power-of-two part of the divisor
    n_sh  = cmd.job[1] ? num[61:9] : num[62:10];
    q_fix = rem_r >= hsgf_pkg::DIV_ODD;
    xs   = x_r >>> cmd.iter;
    ys   = y_r >>> cmd.iter;
    at   = 36'(hsgf_pkg::atan_q30(cmd.iter));
    dir  = (cmd.op == hsgf_pkg::OP_VEC_STEP) ? !y_r[35] : !z_r[35];
    q_s  = neg_r ? -36'(qsh_r) : 36'(qsh_r);
    rem2  = {srem_r, rad_r[61:60]};
    trial = 35'({root_r, 2'b01});
    sge   = rem2 >= trial;
    a_sum = 34'(hs0_r) + prod_r[63:30];
  end

  // result
  logic [55:0] dist_w;
  logic [24:0] dist_s;
  always_comb begin
    dist_w   = 56'(prod_r) + 56'(64'd1 << 29);
    dist_s   = (dist_w[55:30] > 26'(hsgf_pkg::ANTIPODAL_M)) ? hsgf_pkg::ANTIPODAL_M
                                                            : dist_w[54:30];
    lock_nxt = !(dist_s < radius_r);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      hsgf_pkg::OP_LOAD: begin
        flat_r <= flat_s;
        dlat_r <= tlat_r - flat_s;
        dlon_r <= dlon_w[31:0];
      end
      hsgf_pkg::OP_MUL_RAD: begin
        prod_r <= mul_a * mul_b;
        neg_r  <= src[31];
      end
      hsgf_pkg::OP_DIV_LD: n_r <= n_sh;
      // estimate is low by at most two; the last steps correct it
      hsgf_pkg::OP_DIV_STEP: begin
        case (cmd.iter)
          6'd0: prod_r <= mul_a * mul_b;
          6'd1: begin
            qsh_r  <= prod_r[63:32];
            prod_r <= mul_a * mul_b;
          end
          6'd2: rem_r <= 32'(n_r - prod_r[52:0]);
          default: begin
            if (q_fix) begin
              qsh_r <= qsh_r + 32'd1;
              rem_r <= rem_r - hsgf_pkg::DIV_ODD;
            end
          end
        endcase
      end
      hsgf_pkg::OP_ROT_LD: begin
        x_r <= 36'(hsgf_pkg::GAIN_Q30);
        y_r <= '0;
        z_r <= q_s;
      end
      hsgf_pkg::OP_ROT_STEP: begin
        x_r <= dir ? x_r - ys : x_r + ys;
        y_r <= dir ? y_r + xs : y_r - xs;
        z_r <= dir ? z_r - at : z_r + at;
      end
      hsgf_pkg::OP_VEC_STEP: begin
        x_r <= dir ? x_r + ys : x_r - ys;
        y_r <= dir ? y_r - xs : y_r + xs;
        z_r <= dir ? z_r + at : z_r - at;
      end
      hsgf_pkg::OP_TRIG_MUL, hsgf_pkg::OP_CPROD, hsgf_pkg::OP_TERM,
      hsgf_pkg::OP_DIST_MUL: prod_r <= mul_a * mul_b;
      hsgf_pkg::OP_TRIG_ST: begin
        case (cmd.job)
          2'd0:    hs0_r <= prod_r[61:30];
          2'd1:    hs1_r <= prod_r[61:30];
          2'd2:    c2_r  <= c_cl;
          default: c3_r  <= c_cl;
        endcase
      end
      hsgf_pkg::OP_SUM: a_r <= (a_sum > 34'(hsgf_pkg::Q_ONE)) ? hsgf_pkg::Q_ONE : a_sum[31:0];
      hsgf_pkg::OP_SQA_LD: begin
        rad_r  <= {a_r, 30'd0};
        srem_r <= '0;
        root_r <= '0;
      end
      hsgf_pkg::OP_SQB_LD: begin
        rad_r  <= {hsgf_pkg::Q_ONE - a_r, 30'd0};
        srem_r <= '0;
        root_r <= '0;
        ra_r   <= 32'(root_r);
      end
      hsgf_pkg::OP_SQ_STEP: begin
        rad_r  <= {rad_r[59:0], 2'b00};
        srem_r <= sge ? 33'(rem2 - trial) : rem2[32:0];
        root_r <= {root_r[29:0], sge};
      end
      hsgf_pkg::OP_VEC_LD: begin
        x_r <= 36'(root_r);
        y_r <= 36'(ra_r);
        z_r <= '0;
      end
      hsgf_pkg::OP_FINISH: begin
        dist_r    <= dist_s;
        locked_r  <= lock_nxt;
        changed_r <= lock_nxt != lock_r;
      end
      default: ;
    endcase
  end

  assign out_distance_m    = dist_r;
  assign out_locked        = locked_r;
  assign out_state_changed = changed_r;
  assign out_servo_angle   = locked_r ? hsgf_pkg::SERVO_LOCK : hsgf_pkg::SERVO_UNLOCK;

endmodule
`default_nettype wire

### rtl/haversine_geofence_lock_unit.sv
// Top level of the haversine geofence lock: controller plus datapath.
// Depends on hsgf_pkg, hsgf_ctrl and hsgf_dp.
`timescale 1ns / 1ps
`default_nettype none
// Takes one position fix at a time and returns one word per fix: the great-circle
// distance to the target in metres, the lock state, a change flag and the servo
// angle. N = min(CORDIC_ITERATIONS, 48) is the number of CORDIC iterations. A fix
// runs four sine/cosine passes, two square roots at two bits per cycle, one
// arctangent and a few single multiply steps, all on one shared CORDIC unit and
// one 32x32 multiplier. The next fix is taken as soon as the word sits in the
// output register. While an earlier word is still stalled there, the block waits
// in its last step.
// Configuration is always ready and must only be written while the block is idle.
module haversine_geofence_lock_unit #(
  parameter int CORDIC_ITERATIONS = 32
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  signed [30:0] in_fix_lat,
  input  wire  signed [31:0] in_fix_lon,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [24:0]        out_distance_m,
  output logic               out_locked,
  output logic               out_state_changed,
  output logic [6:0]         out_servo_angle,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [1:0]         cfg_index,
  input  wire  [31:0]        cfg_wdata
);

  localparam int ITERS = (CORDIC_ITERATIONS > hsgf_pkg::ATAN_LEN) ? hsgf_pkg::ATAN_LEN
                                                                  : CORDIC_ITERATIONS;

  hsgf_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  hsgf_ctrl #(.ITERS(ITERS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  hsgf_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_fix_lat        (in_fix_lat),
    .in_fix_lon        (in_fix_lon),
    .out_distance_m    (out_distance_m),
    .out_locked        (out_locked),
    .out_state_changed (out_state_changed),
    .out_servo_angle   (out_servo_angle)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted fix did not start work");

  a_servo_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_servo_angle == (out_locked ? hsgf_pkg::SERVO_LOCK
                                                  : hsgf_pkg::SERVO_UNLOCK)))
    else $error("servo angle disagrees with lock state");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_distance_m <= hsgf_pkg::ANTIPODAL_M))
    else $error("distance beyond antipodal value");
`endif

endmodule
`default_nettype wire
